### hdl/iepc_pkg.sv
// Shared types and constants for the interrupt enable, pending and claim core.
// Holds the request codes, the request and response payload structs and the
// default source geometry. Depends on nothing.
`timescale 1ns / 1ps

package iepc_pkg;

   localparam int GROUP_WIDTH_DEF = 32;
   localparam int GROUP_COUNT_DEF = 2;
   localparam int REQ_TYPE_WIDTH  = 3;
   localparam int SRC_WIDTH       = 6;

   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      REQ_ENABLE  = 3'd0,
      REQ_DISABLE = 3'd1,
      REQ_QUERY   = 3'd2,
      REQ_CLEAR   = 3'd3,
      REQ_CLAIM   = 3'd4,
      REQ_RAISE   = 3'd5
   } req_code_type;

   typedef struct packed {
      logic [REQ_TYPE_WIDTH-1:0] req_type;
      logic [SRC_WIDTH-1:0]      source;
   } req_payload_type;

   typedef struct packed {
      logic                 is_enabled;
      logic                 found;
      logic [SRC_WIDTH-1:0] claimed_source;
   } rsp_payload_type;

endpackage

### hdl/iepc_claim_enc.sv
// Fixed-priority claim encoder: picks the lowest set bit of the ready vector.
// Returns a found flag, the one-hot grant and the binary index of the winner.
// Depends on nothing.
`timescale 1ns / 1ps

module iepc_claim_enc #(
   parameter int WIDTH     = 64,
   parameter int IDX_WIDTH = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0]     ready_vec,
   output logic                 found,
   output logic [WIDTH-1:0]     grant,
   output logic [IDX_WIDTH-1:0] index
);

   always_comb begin
      found = |ready_vec;
      grant = ready_vec & (~ready_vec + WIDTH'(1));
      index = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (grant[i]) begin
            index = index | IDX_WIDTH'(i);
         end
      end
   end

endmodule

### hdl/interrupt_enable_pending_claim_core.sv
// Channel  Direction  Ports                           Payload
// request  in         req_valid, req_ready, req_data  iepc_pkg::req_payload_type
// response out        rsp_valid, rsp_ready, rsp_data  iepc_pkg::rsp_payload_type
//
// One request is taken per cycle unless the response stalls; its response is valid
// when the result register loads the outcome computed from the input register.
// The enable and pending masks change at the same edge that loads the result, so
// the next request always sees the updated masks. A stalled response holds both
// stages, and req_ready follows rsp_ready in the same cycle.
// Synchronous reset clears both valid flags and all four masks.
// Depends on iepc_pkg and iepc_claim_enc.
`timescale 1ns / 1ps

module interrupt_enable_pending_claim_core #(
   parameter int GROUP_WIDTH = iepc_pkg::GROUP_WIDTH_DEF,
   parameter int GROUP_COUNT = iepc_pkg::GROUP_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  iepc_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output iepc_pkg::rsp_payload_type rsp_data
);

   localparam int NumSrc   = GROUP_WIDTH * GROUP_COUNT;
   localparam int IdxWidth = $clog2(NumSrc);
   localparam int CmpWidth = iepc_pkg::SRC_WIDTH + 1;

   logic                      stg_vld_ff, stg_vld_in;
   iepc_pkg::req_payload_type stg_req_ff;
   logic                      rsp_vld_ff, rsp_vld_in;
   iepc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [NumSrc-1:0] ienab_ff, ienab_in;
   logic [NumSrc-1:0] eenab_ff, eenab_in;
   logic [NumSrc-1:0] ipend_ff, ipend_in;
   logic [NumSrc-1:0] epend_ff, epend_in;

   logic              stage_go;
   logic              exec;
   logic              in_range;
   logic [NumSrc-1:0] src_bit;
   logic [NumSrc-1:0] claim_ready;
   logic              claim_found;
   logic [NumSrc-1:0] claim_grant;
   logic [IdxWidth-1:0] claim_index;

   assign stage_go  = !rsp_vld_ff || rsp_ready;
   assign exec      = stg_vld_ff && stage_go;
   assign req_ready = !stg_vld_ff || stage_go;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   assign stg_vld_in = req_ready ? req_valid : stg_vld_ff;
   assign rsp_vld_in = stage_go ? stg_vld_ff : rsp_vld_ff;

   assign in_range    = {1'b0, stg_req_ff.source} < CmpWidth'(NumSrc);
   assign src_bit     = in_range ? (NumSrc'(1) << stg_req_ff.source) : '0;
   assign claim_ready = ipend_ff & ienab_ff;

   iepc_claim_enc #(
      .WIDTH     (NumSrc),
      .IDX_WIDTH (IdxWidth)
   ) u_claim_enc (
      .ready_vec (claim_ready),
      .found     (claim_found),
      .grant     (claim_grant),
      .index     (claim_index)
   );

   always_comb begin
      ienab_in    = ienab_ff;
      eenab_in    = eenab_ff;
      ipend_in    = ipend_ff;
      epend_in    = epend_ff;
      rsp_data_in = '0;
      case (stg_req_ff.req_type)
         iepc_pkg::REQ_ENABLE: begin
            ienab_in = ienab_ff | src_bit;
            eenab_in = eenab_ff | src_bit;
         end
         iepc_pkg::REQ_DISABLE: begin
            ienab_in = ienab_ff & ~src_bit;
            eenab_in = eenab_ff & ~src_bit;
         end
         iepc_pkg::REQ_QUERY: begin
            rsp_data_in.is_enabled = |(ienab_ff & eenab_ff & src_bit);
         end
         iepc_pkg::REQ_CLEAR: begin
            ipend_in = ipend_ff & ~src_bit;
            epend_in = epend_ff & ~src_bit;
         end
         iepc_pkg::REQ_CLAIM: begin
            ipend_in = ipend_ff & ~claim_grant;
            epend_in = epend_ff & ~claim_grant;
            rsp_data_in.found          = claim_found;
            rsp_data_in.claimed_source = iepc_pkg::SRC_WIDTH'(claim_index);
         end
         iepc_pkg::REQ_RAISE: begin
            ipend_in = ipend_ff | src_bit;
            epend_in = epend_ff | src_bit;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         ienab_ff   <= '0;
         eenab_ff   <= '0;
         ipend_ff   <= '0;
         epend_ff   <= '0;
      end else begin
         stg_vld_ff <= stg_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (exec) begin
            ienab_ff <= ienab_in;
            eenab_ff <= eenab_in;
            ipend_ff <= ipend_in;
            epend_ff <= epend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_req_ff <= req_data;
      end
      if (exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_enab_match : assert property (@(posedge clock) disable iff (reset)
      ienab_ff == eenab_ff)
      else $error("interrupt and event enable masks diverged");

   a_pend_match : assert property (@(posedge clock) disable iff (reset)
      ipend_ff == epend_ff)
      else $error("interrupt and event pending masks diverged");

   a_claim_clears : assert property (@(posedge clock) disable iff (reset)
      exec && (stg_req_ff.req_type == iepc_pkg::REQ_CLAIM) && claim_found
      |=> (ipend_ff & $past(claim_grant)) == '0)
      else $error("claimed source still pending after claim");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      stg_vld_ff && !stage_go |=> stg_vld_ff && $stable(stg_req_ff))
      else $error("input stage changed while the result stage was stalled");
`endif

endmodule

### bench/interrupt_enable_pending_claim_core_tb.sv
// Self-checking testbench for interrupt_enable_pending_claim_core with valid/ready traffic.
// Predicts every response from its own copy of the enable and pending masks.
// Depends on iepc_pkg and the core RTL.
`timescale 1ns / 1ps

module interrupt_enable_pending_claim_core_tb;

   localparam int NUM_SOURCES = iepc_pkg::GROUP_WIDTH_DEF * iepc_pkg::GROUP_COUNT_DEF;
   localparam logic [iepc_pkg::REQ_TYPE_WIDTH-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [iepc_pkg::REQ_TYPE_WIDTH-1:0] REQ_SPARE_HI = 3'd7;
   localparam int RANDOM_PER_PHASE = 420;
   localparam int HOLDOFF_REQUESTS = 40;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   iepc_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   iepc_pkg::rsp_payload_type rsp_data;

   logic [63:0] intr_enable_q = '0;
   logic [63:0] event_enable_q = '0;
   logic [63:0] intr_pending_q = '0;
   logic [63:0] event_pending_q = '0;

   iepc_pkg::rsp_payload_type predicted_rsp_q[$];
   int unsigned error_count = 0;
   int unsigned response_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_seq = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   interrupt_enable_pending_claim_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic iepc_pkg::rsp_payload_type predict_response(input logic [2:0] code,
                                                                  input logic [5:0] src);
      iepc_pkg::rsp_payload_type r;
      logic [63:0] src_mask;
      logic [63:0] claimable;
      logic [63:0] source_span;
      r = '0;
      src_mask = (int'(src) < NUM_SOURCES) ? (64'd1 << src) : 64'd0;
      source_span = (NUM_SOURCES >= 64) ? '1 : ((64'd1 << NUM_SOURCES) - 64'd1);
      case (code)
         iepc_pkg::REQ_ENABLE: begin
            intr_enable_q = intr_enable_q | src_mask;
            event_enable_q = event_enable_q | src_mask;
         end
         iepc_pkg::REQ_DISABLE: begin
            intr_enable_q = intr_enable_q & ~src_mask;
            event_enable_q = event_enable_q & ~src_mask;
         end
         iepc_pkg::REQ_QUERY: begin
            r.is_enabled = |(intr_enable_q & event_enable_q & src_mask);
         end
         iepc_pkg::REQ_CLEAR: begin
            intr_pending_q = intr_pending_q & ~src_mask;
            event_pending_q = event_pending_q & ~src_mask;
         end
         iepc_pkg::REQ_RAISE: begin
            intr_pending_q = intr_pending_q | src_mask;
            event_pending_q = event_pending_q | src_mask;
         end
         iepc_pkg::REQ_CLAIM: begin
            claimable = intr_pending_q & intr_enable_q & source_span;
            for (int i = 0; i < 64; i++) begin
               if (claimable[i] && !r.found) begin
                  r.found = 1'b1;
                  r.claimed_source = 6'(i);
                  intr_pending_q[i] = 1'b0;
                  event_pending_q[i] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 100) begin
         $display("MISMATCH response %0d: %s", response_count, what);
      end
      error_count++;
   endtask

   // Called at a rising edge; returns at the edge where the request is accepted.
   task automatic send_request(input logic [2:0] code, input logic [5:0] src);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: code, source: src};
      do @(posedge clock); while (!req_ready);
      predicted_rsp_q.push_back(predict_response(code, src));
   endtask

   function automatic iepc_pkg::req_payload_type random_request();
      iepc_pkg::req_payload_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 18) r.req_type = iepc_pkg::REQ_ENABLE;
      else if (pick < 26) r.req_type = iepc_pkg::REQ_DISABLE;
      else if (pick < 40) r.req_type = iepc_pkg::REQ_QUERY;
      else if (pick < 50) r.req_type = iepc_pkg::REQ_CLEAR;
      else if (pick < 72) r.req_type = iepc_pkg::REQ_CLAIM;
      else if (pick < 95) r.req_type = iepc_pkg::REQ_RAISE;
      else if (pick < 98) r.req_type = REQ_SPARE_LO;
      else r.req_type = REQ_SPARE_HI;
      if ($urandom_range(1) == 0) r.source = 6'($urandom_range(63));
      else if ($urandom_range(1) == 0) r.source = 6'($urandom_range(28, 35));
      else r.source = 6'($urandom_range(56, 63));
      return r;
   endfunction

   task automatic test_directed();
      send_request(iepc_pkg::REQ_CLAIM, 6'd0);
      send_request(iepc_pkg::REQ_CLAIM, 6'd63);
      send_request(iepc_pkg::REQ_QUERY, 6'd63);
      send_request(iepc_pkg::REQ_ENABLE, 6'd0);
      send_request(iepc_pkg::REQ_ENABLE, 6'd63);
      send_request(iepc_pkg::REQ_ENABLE, 6'd32);
      send_request(iepc_pkg::REQ_ENABLE, 6'd31);
      send_request(iepc_pkg::REQ_QUERY, 6'd0);
      send_request(iepc_pkg::REQ_QUERY, 6'd63);
      send_request(iepc_pkg::REQ_RAISE, 6'd63);
      send_request(iepc_pkg::REQ_RAISE, 6'd32);
      send_request(iepc_pkg::REQ_RAISE, 6'd31);
      send_request(iepc_pkg::REQ_RAISE, 6'd10);
      send_request(iepc_pkg::REQ_CLAIM, 6'd42);
      send_request(iepc_pkg::REQ_CLAIM, 6'd0);
      send_request(iepc_pkg::REQ_CLAIM, 6'd0);
      send_request(iepc_pkg::REQ_CLAIM, 6'd0);
      send_request(REQ_SPARE_LO, 6'd63);
      send_request(REQ_SPARE_HI, 6'd42);
      send_request(iepc_pkg::REQ_CLEAR, 6'd10);
      send_request(iepc_pkg::REQ_DISABLE, 6'd63);
      send_request(iepc_pkg::REQ_QUERY, 6'd63);
      send_request(iepc_pkg::REQ_RAISE, 6'd0);
      send_request(iepc_pkg::REQ_CLEAR, 6'd0);
      send_request(iepc_pkg::REQ_CLAIM, 6'd21);
   endtask

   task automatic test_random(input int unsigned count);
      iepc_pkg::req_payload_type r;
      repeat (count) begin
         r = random_request();
         send_request(r.req_type, r.source);
      end
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // core fills up and drops req_ready.
   task automatic test_receiver_holdoff();
      hold_seq <= hold_seq + 1;
      test_random(HOLDOFF_REQUESTS);
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      iepc_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", rsp_data));
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_data.is_enabled !== want.is_enabled)
               report_mismatch($sformatf("is_enabled %b, expected %b",
                                         rsp_data.is_enabled, want.is_enabled));
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_data.found, want.found));
            if (rsp_data.claimed_source !== want.claimed_source)
               report_mismatch($sformatf("claimed_source %0d, expected %0d",
                                         rsp_data.claimed_source, want.claimed_source));
         end
         response_count++;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("interrupt_enable_pending_claim_core_tb failed");
      $finish;
   end

   initial begin
      send_idle_pct = 14;
      recv_idle_pct <= 53;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(RANDOM_PER_PHASE);
      send_idle_pct = 53;
      recv_idle_pct <= 14;
      test_random(RANDOM_PER_PHASE);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_receiver_holdoff();
      test_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("interrupt_enable_pending_claim_core_tb passed");
      end else begin
         $display("interrupt_enable_pending_claim_core_tb failed");
      end
      $finish;
   end

endmodule

### files.f
hdl/iepc_pkg.sv
hdl/iepc_claim_enc.sv
hdl/interrupt_enable_pending_claim_core.sv
bench/interrupt_enable_pending_claim_core_tb.sv
